/* src/mts_pkg.sv */
// Shared constants, codes and control types for the min-tracking stack.
// No dependencies; every other file imports it.
package mts_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int DATA_W   = 32;
  localparam int WORD_W   = DATA_W + 2;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic exec;   // apply the accepted beat to the stack state
    logic load;   // capture the result into the output register
  } mts_cmd_t;

endpackage

/* src/min_tracking_stack.sv */
// Top level of the min-tracking stack: joins controller and datapath.
// Depends on mts_pkg, mts_ctrl and mts_dp.
//
// Signed 32-bit stack that returns, for every push or pop beat, a status,
// the decoded top, the running minimum, an empty flag and the entry count
// (top and minimum read -1 when empty). Minimum-setting pushes are stored as
// 34-bit words 2*value-minimum so the previous minimum comes back on pop.
// One item is handled at a time: the accept cycle updates level, minimum and
// memory and, on a pop, starts the read of the new top from the single-port
// synchronous stack memory; then S_EMIT loads the result register once the
// output register is empty or being taken. in_ready rises with that load,
// so back-pressure on the output stalls the input. No clearing pass follows
// reset.
module min_tracking_stack (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic signed [mts_pkg::DATA_W-1:0]   push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [mts_pkg::STATUS_W-1:0] status,
  output logic signed [mts_pkg::DATA_W-1:0]   top_value,
  output logic signed [mts_pkg::DATA_W-1:0]   min_value,
  output logic                                is_empty,
  output logic        [mts_pkg::COUNT_W-1:0]  entry_count
);
  import mts_pkg::*;

  mts_cmd_t cmd_bus;

  // sequencing and handshake
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd_o     (cmd_bus)
  );

  // stack storage and arithmetic
  mts_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd_i       (cmd_bus),
    .cmd         (cmd),
    .push_value  (push_value),
    .status      (status),
    .top_value   (top_value),
    .min_value   (min_value),
    .is_empty    (is_empty),
    .entry_count (entry_count)
  );

endmodule

/* src/mts_ctrl.sv */
// Controller for the min-tracking stack: handshake and sequencing.
// Depends on mts_pkg; drives mts_dp through a mts_cmd_t command bundle.
module mts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mts_pkg::mts_cmd_t cmd_o
);
  import mts_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state;

  // command decode
  assign cmd_o.exec = (state == S_IDLE) && in_valid && in_ready;
  assign cmd_o.load = (state == S_EMIT) && (!out_valid || out_ready);

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (out_ready) out_valid <= 1'b0;
          if (cmd_o.exec) begin
            state    <= S_EMIT;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        S_EMIT: begin
          if (cmd_o.load) begin
            state     <= S_IDLE;
            in_ready  <= 1'b1;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* src/mts_dp.sv */
// Datapath for the min-tracking stack: stack memory, level, running minimum,
// cached top word and result register. Depends on mts_pkg.
module mts_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  mts_pkg::mts_cmd_t                   cmd_i,
  input  logic                                cmd,
  input  logic signed [mts_pkg::DATA_W-1:0]   push_value,
  output logic        [mts_pkg::STATUS_W-1:0] status,
  output logic signed [mts_pkg::DATA_W-1:0]   top_value,
  output logic signed [mts_pkg::DATA_W-1:0]   min_value,
  output logic                                is_empty,
  output logic        [mts_pkg::COUNT_W-1:0]  entry_count
);
  import mts_pkg::*;

  localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(STACK_DEPTH);

  logic signed [WORD_W-1:0] mem [STACK_DEPTH];
  logic signed [WORD_W-1:0] rdata;
  logic signed [WORD_W-1:0] top_word;
  logic signed [DATA_W-1:0] run_min;
  logic        [LVL_W-1:0]  level;
  logic                     use_rd;
  logic      [STATUS_W-1:0] st_reg;

  logic                     empty;
  logic                     full;
  logic signed [WORD_W-1:0] v_ext;
  logic signed [WORD_W-1:0] min_ext;
  logic signed [WORD_W-1:0] enc_word;
  logic signed [WORD_W-1:0] wr_word;
  logic signed [DATA_W-1:0] restored;
  logic        [LVL_W-1:0]  lvl_m2;
  logic        [ADDR_W-1:0] rd_addr;
  logic        [ADDR_W-1:0] wr_addr;
  logic                     do_push;
  logic                     do_pop_rd;
  logic signed [WORD_W-1:0] w_sel;
  logic signed [DATA_W-1:0] top_dec;

  // push encoding, pop restore and top decode
  always_comb begin
    empty     = (level == '0);
    full      = (level == FULL_LVL);
    v_ext     = WORD_W'(push_value);
    min_ext   = WORD_W'(run_min);
    enc_word  = (v_ext <<< 1) - min_ext;
    if (empty || (push_value > run_min)) wr_word = v_ext;
    else                                 wr_word = enc_word;
    restored  = (run_min <<< 1) - top_word[DATA_W-1:0];
    lvl_m2    = level - LVL_W'(2);
    rd_addr   = lvl_m2[ADDR_W-1:0];
    wr_addr   = level[ADDR_W-1:0];
    do_push   = cmd_i.exec && (cmd == CMD_PUSH) && !full;
    do_pop_rd = cmd_i.exec && (cmd == CMD_POP) && (level > LVL_W'(1));
    w_sel     = use_rd ? rdata : top_word;
    top_dec   = (w_sel < min_ext) ? run_min : w_sel[DATA_W-1:0];
  end

  // stack memory, synchronous read
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_addr] <= wr_word;
    if (do_pop_rd) rdata <= mem[rd_addr];
  end

  // stack state update on an accepted beat, top refresh on result load
  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= '0;
      run_min <= '0;
      use_rd  <= 1'b0;
    end else if (cmd_i.exec) begin
      if (cmd == CMD_PUSH) begin
        use_rd <= 1'b0;
        if (full) begin
          st_reg <= ST_PUSH_FULL;
        end else begin
          st_reg   <= ST_OK;
          level    <= level + LVL_W'(1);
          top_word <= wr_word;
          if (empty || (push_value <= run_min)) run_min <= push_value;
        end
      end else begin
        if (empty) begin
          st_reg <= ST_POP_EMPTY;
          use_rd <= 1'b0;
        end else begin
          st_reg <= ST_OK;
          level  <= level - LVL_W'(1);
          if (top_word < min_ext) run_min <= restored;
          use_rd <= (level > LVL_W'(1));
        end
      end
    end else if (cmd_i.load) begin
      if (use_rd) top_word <= rdata;
      use_rd <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      status      <= st_reg;
      is_empty    <= empty;
      entry_count <= COUNT_W'(level);
      if (empty) begin
        top_value <= -32'sd1;
        min_value <= -32'sd1;
      end else begin
        top_value <= top_dec;
        min_value <= run_min;
      end
    end
  end

endmodule

/* src/mts_checker.sv */
// Port-level assertions for the min-tracking stack, bound to the top level.
// Depends on mts_pkg and min_tracking_stack.
module mts_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic        [mts_pkg::STATUS_W-1:0] status,
  input logic signed [mts_pkg::DATA_W-1:0]   top_value,
  input logic signed [mts_pkg::DATA_W-1:0]   min_value,
  input logic                                is_empty,
  input logic        [mts_pkg::COUNT_W-1:0]  entry_count
);
  import mts_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(top_value)
      && $stable(min_value) && $stable(entry_count))
    else $error("stalled result changed");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // empty result reads -1 / -1 with zero count
  a_empty_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> top_value == -32'sd1 && min_value == -32'sd1
      && entry_count == '0)
    else $error("empty result fields wrong");

  // the minimum never exceeds the decoded top
  a_min_le_top: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_empty |-> min_value <= top_value && entry_count != '0)
    else $error("minimum above top");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);
